// ----- rtl/eicc_pkg.sv -----
// eicc_pkg: shared types and constants of the event interval clash counter
// request codes, config register indexes, entry layout, controller/datapath structs
// no dependencies
package eicc_pkg;

  localparam int DEF_TABLE_DEPTH = 128;

  localparam int START_W = 32;
  localparam int DUR_W   = 16;
  localparam int FLAGS_W = 8;
  localparam int ENTRY_W = START_W + DUR_W + 1 + FLAGS_W;
  localparam int SUM_W   = START_W + 1;

  localparam int REQ_W   = 2;
  localparam int IDX_W   = 7;
  localparam int COUNT_W = 13;
  localparam int ECNT_W  = 8;
  localparam int GRACE_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_ONE   = 2'd1,
    REQ_PAIRS = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EVENT_COUNT = 2'd0,
    CFG_GRACE       = 2'd1,
    CFG_FLAG_MASK   = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic load_req;
    logic rd_a;
    logic rd_a_from_i;
    logic latch_a;
    logic i_init;
    logic i_inc;
    logic j_init_zero;
    logic j_init_next;
    logic j_inc;
    logic rd_b;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic idx_ok;
    logic n_zero;
    logic i_last;
    logic j_last;
    logic a_cand;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/eicc_ctrl.sv -----
// eicc_ctrl: sequencing state machine of the clash counter
// drives datapath commands from status; uses eicc_pkg
module eicc_ctrl
  import eicc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_A_RD    = 9'b000000100,
    S_A_LATCH = 9'b000001000,
    S_A_CHK   = 9'b000010000,
    S_SCAN    = 9'b000100000,
    S_DRAIN   = 9'b001000000,
    S_NEXT_I  = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.req == REQ_ONE) begin
          state_next = sts.idx_ok ? S_A_RD : S_FINISH;
        end else if (sts.req == REQ_PAIRS) begin
          cmd.i_init = 1'b1;
          state_next = sts.n_zero ? S_FINISH : S_A_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_A_RD: begin
        cmd.rd_a        = 1'b1;
        cmd.rd_a_from_i = (sts.req == REQ_PAIRS);
        state_next      = S_A_LATCH;
      end
      S_A_LATCH: begin
        cmd.latch_a = 1'b1;
        state_next  = S_A_CHK;
      end
      S_A_CHK: begin
        priority if (sts.req == REQ_ONE) begin
          if (!sts.a_cand || sts.n_zero) begin
            state_next = S_FINISH;
          end else begin
            cmd.j_init_zero = 1'b1;
            state_next      = S_SCAN;
          end
        end else begin
          if (!sts.a_cand || sts.i_last) begin
            state_next = S_NEXT_I;
          end else begin
            cmd.j_init_next = 1'b1;
            state_next      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_b  = 1'b1;
        cmd.j_inc = 1'b1;
        if (sts.j_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = (sts.req == REQ_ONE) ? S_FINISH : S_NEXT_I;
      end
      S_NEXT_I: begin
        if (sts.i_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_A_RD;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/eicc_dpath.sv -----
// eicc_dpath: event table, config registers, interval compare and result register
// single-port table read, one entry compared per cycle; uses eicc_pkg
module eicc_dpath
  import eicc_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic [REQ_W-1:0]          req_type,
  input  logic [IDX_W-1:0]          event_index,
  input  logic signed [START_W-1:0] start_minute,
  input  logic signed [DUR_W-1:0]   duration_minutes,
  input  logic                      is_timed,
  input  logic [FLAGS_W-1:0]        event_flags,
  input  logic signed [START_W-1:0] now_minute,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COUNT_W-1:0]        clash_count,
  output logic [IDX_W-1:0]          first_index,
  output logic                      first_found,
  input  cmd_t                      cmd,
  output status_t                   sts
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = ($clog2(TABLE_DEPTH + 1) > ECNT_W) ? $clog2(TABLE_DEPTH + 1) : ECNT_W;
  localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [AW-1:0]      rd_addr;

  logic [ECNT_W-1:0]  n_events;
  logic [GRACE_W-1:0] grace_minutes;
  logic [FLAGS_W-1:0] clash_flag_mask;

  req_t                      req_q;
  logic [IDX_W-1:0]          idx_q;
  logic signed [SUM_W-1:0]   now_q;

  logic [NW-1:0] n_live;
  logic [NW-1:0] idx_n;
  logic [NW-1:0] i_cnt;
  logic [NW-1:0] j_cnt;
  logic [NW-1:0] scan_idx;
  logic          scan_v;

  logic signed [SUM_W-1:0] a_start;
  logic signed [SUM_W-1:0] a_end;
  logic                    a_cand;

  logic signed [SUM_W-1:0] b_start;
  logic signed [SUM_W-1:0] b_len;
  logic signed [SUM_W-1:0] b_end;
  logic signed [DUR_W-1:0] b_dur;
  logic                    b_cand;
  logic                    hit;

  logic [COUNT_W-1:0] acc_count;
  logic [IDX_W-1:0]   acc_first;
  logic               acc_found;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      n_events        <= '0;
      grace_minutes   <= '0;
      clash_flag_mask <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_EVENT_COUNT: n_events        <= cfg_data[ECNT_W-1:0];
        CFG_GRACE:       grace_minutes   <= cfg_data[GRACE_W-1:0];
        CFG_FLAG_MASK:   clash_flag_mask <= cfg_data[FLAGS_W-1:0];
        CFG_UNUSED:      ;
      endcase
    end
  end

  assign n_live = (NW'(n_events) < DEPTH_N) ? NW'(n_events) : DEPTH_N;
  assign idx_n  = NW'(idx_q);

  // request capture and table write
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req_t'(req_type);
      idx_q <= event_index;
      now_q <= SUM_W'(now_minute);
      if (req_t'(req_type) == REQ_WRITE && NW'(event_index) < DEPTH_N) begin
        mem[AW'(NW'(event_index))] <= {start_minute, duration_minutes, is_timed, event_flags};
      end
    end
  end

  always_comb begin
    priority if (cmd.rd_b) begin
      rd_addr = AW'(j_cnt);
    end else if (cmd.rd_a && cmd.rd_a_from_i) begin
      rd_addr = AW'(i_cnt);
    end else begin
      rd_addr = AW'(idx_n);
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // interval of the entry just read
  assign b_dur   = rd_data[FLAGS_W+1 +: DUR_W];
  assign b_start = SUM_W'(signed'(rd_data[FLAGS_W+1+DUR_W +: START_W]));
  assign b_len   = (b_dur > 0) ? SUM_W'(b_dur) : signed'(SUM_W'(grace_minutes));
  assign b_end   = b_start + b_len;
  assign b_cand  = rd_data[FLAGS_W] && (|(rd_data[FLAGS_W-1:0] & clash_flag_mask))
                   && (b_end > now_q);
  assign hit     = scan_v && b_cand && (a_start < b_end) && (b_start < a_end)
                   && !(req_q == REQ_ONE && scan_idx == idx_n);

  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      a_start <= b_start;
      a_end   <= b_end;
      a_cand  <= b_cand;
    end
  end

  // index counters
  always_ff @(posedge clk) begin
    if (cmd.i_init) begin
      i_cnt <= '0;
    end else if (cmd.i_inc) begin
      i_cnt <= i_cnt + 1'b1;
    end
    if (cmd.j_init_zero) begin
      j_cnt <= '0;
    end else if (cmd.j_init_next) begin
      j_cnt <= i_cnt + 1'b1;
    end else if (cmd.j_inc) begin
      j_cnt <= j_cnt + 1'b1;
    end
    scan_idx <= j_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_v <= 1'b0;
    end else begin
      scan_v <= cmd.rd_b;
    end
  end

  // clash accumulation
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      acc_count <= '0;
      acc_first <= '0;
      acc_found <= 1'b0;
    end else if (hit) begin
      if (acc_count != COUNT_MAX) begin
        acc_count <= acc_count + 1'b1;
      end
      if (req_q == REQ_ONE && !acc_found) begin
        acc_found <= 1'b1;
        acc_first <= IDX_W'(scan_idx);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      clash_count <= acc_count;
      first_index <= acc_first;
      first_found <= acc_found;
    end
  end

  always_comb begin
    sts.req      = req_q;
    sts.idx_ok   = idx_n < DEPTH_N;
    sts.n_zero   = (n_live == '0);
    sts.i_last   = (i_cnt == n_live - 1'b1);
    sts.j_last   = (j_cnt == n_live - 1'b1);
    sts.a_cand   = a_cand;
    sts.out_free = !out_valid || !out_stall;
  end

endmodule

// ----- rtl/event_interval_clash_counter_unit.sv -----
// event interval clash counter, one request at a time through a single-port table
// write: result after the decode and finish states; single-entry query: one scan of the n live entries
// pair count: for each candidate entry, one scan of the entries after it, n = live entries, one table read a cycle
// next input beat taken once the result is in the output register, even if it waits
// rst is synchronous: clears config registers and control, table contents stay undefined
// uses eicc_pkg, eicc_ctrl, eicc_dpath
module event_interval_clash_counter_unit
  import eicc_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [REQ_W-1:0]          req_type,
  input  logic [IDX_W-1:0]          event_index,
  input  logic signed [START_W-1:0] start_minute,
  input  logic signed [DUR_W-1:0]   duration_minutes,
  input  logic                      is_timed,
  input  logic [FLAGS_W-1:0]        event_flags,
  input  logic signed [START_W-1:0] now_minute,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COUNT_W-1:0]        clash_count,
  output logic [IDX_W-1:0]          first_index,
  output logic                      first_found
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  eicc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  eicc_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req_type         (req_type),
    .event_index      (event_index),
    .start_minute     (start_minute),
    .duration_minutes (duration_minutes),
    .is_timed         (is_timed),
    .event_flags      (event_flags),
    .now_minute       (now_minute),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .clash_count      (clash_count),
    .first_index      (first_index),
    .first_found      (first_found),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// ----- rtl/eicc_checker.sv -----
// eicc_checker: port-level assertions for the clash counter, bound to the top level
// uses eicc_pkg widths
module eicc_checker
  import eicc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COUNT_W-1:0] clash_count,
  input logic [IDX_W-1:0]   first_index,
  input logic               first_found
);

  // result beat held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(clash_count)
      && $stable(first_index) && $stable(first_found))
    else $error("result beat changed while stalled");

  a_found_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_found |-> clash_count != '0)
    else $error("first entry reported without a clash");

  a_index_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !first_found |-> first_index == '0)
    else $error("first index set without a found entry");

  // one request in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a beat");

endmodule

bind event_interval_clash_counter_unit eicc_checker u_eicc_checker (.*);
